>>> rtl/ihb_pkg.sv
// Shared types and constants for the IPv4 header builder.
// No dependencies; imported by every module under rtl/.
package ihb_pkg;

    localparam int HDR_WORDS   = 10;
    localparam int IDX_W       = 4;
    localparam int PADDR_W     = 3;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 16;

    localparam logic [15:0] HDR_BYTES     = 16'd20;
    localparam logic [15:0] VER_IHL_TOS   = 16'h4500;
    localparam logic [15:0] FLAGS_FRAG    = 16'h4000;
    localparam logic [7:0]  TTL_DEFAULT   = 8'h80;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

    // register index (paddr[2]) for the source address register
    localparam logic REG_SOURCE_ADDR = 1'b0;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] dest_addr;
        logic [15:0] payload_length;
    } req_t;

    typedef struct packed {
        logic [HDR_WORDS-1:0][15:0] words;
        logic                       length_error;
    } hdr_t;

endpackage

>>> rtl/ihb_calc.sv
// Combinational header assembly and RFC 1071 checksum for one request.
// Depends on ihb_pkg.
module ihb_calc
    import ihb_pkg::*;
(
    input  req_t        req,
    input  logic [15:0] packet_id,
    input  logic [31:0] source_addr,
    output hdr_t        hdr
);

    logic [16:0] total;
    logic [15:0] w1, w4;
    logic [19:0] sum_raw;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb begin
        total = {1'b0, req.payload_length} + {1'b0, HDR_BYTES};
        w1    = total[15:0];
        w4    = {TTL_DEFAULT, req.protocol};

        // nine words < 2^20, so two folds settle the carries
        sum_raw = 20'(VER_IHL_TOS) + 20'(w1) + 20'(packet_id) + 20'(FLAGS_FRAG)
                + 20'(w4) + 20'(source_addr[31:16]) + 20'(source_addr[15:0])
                + 20'(req.dest_addr[31:16]) + 20'(req.dest_addr[15:0]);
        fold1 = {1'b0, sum_raw[15:0]} + {13'd0, sum_raw[19:16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};

        hdr.words[0]     = VER_IHL_TOS;
        hdr.words[1]     = w1;
        hdr.words[2]     = packet_id;
        hdr.words[3]     = FLAGS_FRAG;
        hdr.words[4]     = w4;
        hdr.words[5]     = ~fold2;
        hdr.words[6]     = source_addr[31:16];
        hdr.words[7]     = source_addr[15:0];
        hdr.words[8]     = req.dest_addr[31:16];
        hdr.words[9]     = req.dest_addr[15:0];
        hdr.length_error = total[16];
    end

endmodule

>>> rtl/ihb_serializer.sv
// Result register for one header and the word counter that drives the m_ channel.
// Depends on ihb_pkg.
module ihb_serializer
    import ihb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load_valid,
    input  hdr_t        load_hdr,
    output logic        load_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // header_word
    output logic        m_tlast,   // last_word
    output logic        m_tuser    // length_error
);

    logic                       busy_reg, busy_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [HDR_WORDS-1:0][15:0] words_reg, words_next;
    logic                       err_reg, err_next;
    logic                       done, load;

    assign done       = busy_reg && m_tready && (idx_reg == LAST_IDX);
    assign load_ready = !busy_reg || done;
    assign load       = load_valid && load_ready;

    always_comb begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        words_next = words_reg;
        err_next   = err_reg;
        if (busy_reg && m_tready) begin
            if (idx_reg == LAST_IDX) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        if (load) begin
            busy_next  = 1'b1;
            idx_next   = '0;
            words_next = load_hdr.words;
            err_next   = load_hdr.length_error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
        words_reg <= words_next;
        err_reg   <= err_next;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = words_reg[idx_reg];
    assign m_tlast  = (idx_reg == LAST_IDX);
    assign m_tuser  = err_reg;

    a_load_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && idx_reg == '0)
        else $error("load did not restart the word counter");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg <= LAST_IDX)
        else $error("word counter out of range");

    a_idx_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_tready && idx_reg != LAST_IDX && !load
        |=> idx_reg == $past(idx_reg) + IDX_W'(1))
        else $error("word counter skipped");

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done && !load |=> !busy_reg)
        else $error("output stayed busy after last word");

endmodule

>>> rtl/ipv4_header_builder_core.sv
// IPv4 header builder: request register, header/checksum logic, word serializer.
// Depends on ihb_pkg, ihb_calc, ihb_serializer.
//
// Usage:
//   s_ channel takes one send request per word: s_tdata = payload_length [15:0],
//   dest_addr [47:16], protocol [55:48]. m_ channel returns the ten 16-bit words
//   of the 20-byte header in wire order; m_tlast marks the tenth word, m_tuser
//   carries the length error flag (payload + 20 above 65535) on all ten words.
//   APB register 0 (byte address 0) holds the source address; write it only
//   while no header is pending.
// Path: when the serializer is idle, a taken request passes the request register,
//   then the result register, before the first header word is valid.
// Throughput: one word per cycle on the 16-bit m_ channel while m_tready is high;
//   the next request waits in the input register and is loaded into the result
//   register in the cycle the previous tenth word is taken, so words stream
//   without gaps.
// Reset (aresetn low, synchronous): both channels empty, identification counter
//   and source address cleared.
// When m_tready is low the current word holds; one request is still absorbed
//   into the input register, then s_tready drops.
module ipv4_header_builder_core
    import ihb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // payload_length, dest_addr, protocol
    // header word channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // header_word
    output logic                 m_tlast,   // last_word
    output logic                 m_tuser,   // length_error
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic        req_valid_reg, req_valid_next;
    req_t        req_reg, req_next;
    logic [15:0] packet_id_reg, packet_id_next;
    logic [31:0] source_addr_reg, source_addr_next;
    logic        load_ready, load;
    logic        cfg_wr;
    hdr_t        hdr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SOURCE_ADDR);
    assign prdata = (paddr[2] == REG_SOURCE_ADDR) ? source_addr_reg : 32'd0;

    assign load     = req_valid_reg && load_ready;
    assign s_tready = !req_valid_reg || load_ready;

    always_comb begin
        req_valid_next   = req_valid_reg;
        req_next         = req_reg;
        packet_id_next   = packet_id_reg;
        source_addr_next = source_addr_reg;
        if (load) begin
            req_valid_next = 1'b0;
            packet_id_next = packet_id_reg + 16'd1;
        end
        if (s_tvalid && s_tready) begin
            req_valid_next = 1'b1;
            req_next       = req_t'(s_tdata);
        end
        if (cfg_wr) begin
            source_addr_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg   <= 1'b0;
            packet_id_reg   <= '0;
            source_addr_reg <= '0;
        end else begin
            req_valid_reg   <= req_valid_next;
            packet_id_reg   <= packet_id_next;
            source_addr_reg <= source_addr_next;
        end
        req_reg <= req_next;
    end

    ihb_calc u_calc (
        .req         (req_reg),
        .packet_id   (packet_id_reg),
        .source_addr (source_addr_reg),
        .hdr         (hdr)
    );

    ihb_serializer u_ser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (req_valid_reg),
        .load_hdr   (hdr),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    a_id_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> packet_id_reg == $past(packet_id_reg) + 16'd1)
        else $error("identification did not advance on load");

    a_id_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> packet_id_reg == $past(packet_id_reg))
        else $error("identification changed without a load");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> req_valid_reg)
        else $error("accepted request not held");

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid_reg && !load |-> !s_tready)
        else $error("request register could be overwritten");

endmodule
